### src/cartridge_bank_mapper_with_security_defines.svh
// Assertion macros used by the checker file.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_SECURITY_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_SECURITY_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define CBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define CBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// What must hold in the cycle after reset is seen low.
`define CBM_ASSERT_RST(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

### src/cbm_pkg.sv
package cbm_pkg;

    // commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_SCAN  = 2'd2;

    // pattern table modes
    localparam logic [1:0] PAT_FULL  = 2'd0;
    localparam logic [1:0] PAT_LOWER = 2'd1;
    localparam logic [1:0] PAT_UPPER = 2'd2;

    // write decode
    localparam logic [15:0] ADDR_FORCE  = 16'h5100;
    localparam logic [7:0]  DATA_FORCE  = 8'h06;
    localparam logic [15:0] ADDR_STROBE = 16'h5101;
    localparam logic [15:0] WR_MASK     = 16'h7300;
    localparam logic [15:0] WR_BANK_LO  = 16'h5000;
    localparam logic [15:0] WR_BANK_HI  = 16'h5200;
    localparam logic [15:0] WR_SECURITY = 16'h5300;

    // read decode
    localparam logic [15:0] RD_MASK     = 16'h7700;
    localparam logic [15:0] RD_ID_0     = 16'h5000;
    localparam logic [15:0] RD_SECURITY = 16'h5100;
    localparam logic [15:0] RD_ID_2     = 16'h5200;
    localparam logic [15:0] RD_ID_3     = 16'h5300;
    localparam logic [15:0] RD_ID_4     = 16'h5400;
    localparam logic [15:0] RD_TOGGLED  = 16'h5500;
    localparam logic [15:0] RD_ID_6     = 16'h5600;
    localparam logic [15:0] RD_ID_7     = 16'h5700;
    localparam logic [7:0]  READ_ID     = 8'h04;

    localparam logic [8:0] LINE_UPPER = 9'd128;
    localparam logic [8:0] LINE_LOWER = 9'd240;

    localparam logic [7:0] BANK_RESET  = 8'h0F;
    localparam logic [7:0] FORCE_BANK  = 8'd3;
    localparam logic [7:0] LIMIT_RESET = 8'hFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  open_bus;
        logic [8:0]  scanline;
        logic        rendering_on;
        logic        in_vblank;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_stage;

    function automatic logic [7:0] limit_bank(input logic [7:0] bank,
                                              input logic [7:0] limit);
        limit_bank = (bank > limit) ? (bank & limit) : bank;
    endfunction

endpackage

### src/cbm_if.sv
interface cbm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  open_bus;
    logic [8:0]  scanline;
    logic        rendering_on;
    logic        in_vblank;

    modport source (output valid, cmd, address, data, open_bus, scanline,
                    rendering_on, in_vblank, input ready);
    modport sink (input valid, cmd, address, data, open_bus, scanline,
                  rendering_on, in_vblank, output ready);
endinterface

interface cbm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] prg_bank;
    logic [1:0] pattern_mode;

    modport source (output valid, read_data, prg_bank, pattern_mode, input ready);
    modport sink (input valid, read_data, prg_bank, pattern_mode, output ready);
endinterface

### src/cbm_in_stage.sv
module cbm_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cbm_in_if.sink         i_in,
    input  logic           i_take,
    output cbm_pkg::t_stage o_stage
);
    import cbm_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    logic  w_load;

    // refill whenever empty or the held item moves on this cycle
    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.cmd          <= i_in.cmd;
            r_item.address      <= i_in.address;
            r_item.data         <= i_in.data;
            r_item.open_bus     <= i_in.open_bus;
            r_item.scanline     <= i_in.scanline;
            r_item.rendering_on <= i_in.rendering_on;
            r_item.in_vblank    <= i_in.in_vblank;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.item  = r_item;

endmodule

### src/cbm_core.sv
module cbm_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  cbm_pkg::t_stage i_stage,
    output logic            o_take,
    cbm_out_if.source       o_out
);
    import cbm_pkg::*;

    logic [7:0] r_limit_val;
    logic [7:0] r_bank_reg,  n_bank_reg;
    logic [7:0] r_mapped,    n_mapped;
    logic       r_split,     n_split;
    logic       r_strobe_nz, n_strobe_nz;
    logic [7:0] r_security,  n_security;
    logic       r_toggle,    n_toggle;
    logic [1:0] r_pattern,   n_pattern;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_rd_data,   n_rd_data;
    logic       w_fire;
    t_item      w_it;

    assign w_it   = i_stage.item;
    assign o_take = i_stage.valid && (!r_out_valid || o_out.ready);
    assign w_fire = o_take;

    always_comb begin
        n_bank_reg  = r_bank_reg;
        n_mapped    = r_mapped;
        n_split     = r_split;
        n_strobe_nz = r_strobe_nz;
        n_security  = r_security;
        n_toggle    = r_toggle;
        n_pattern   = r_pattern;
        n_rd_data   = w_it.open_bus;
        n_out_valid = r_out_valid && !o_out.ready;
        if (w_fire) begin
            n_out_valid = 1'b1;
            case (w_it.cmd)
                CMD_WRITE: begin
                    if (w_it.address == ADDR_FORCE && w_it.data == DATA_FORCE) begin
                        // forced bank skips the limit
                        n_mapped = FORCE_BANK;
                    end else if (w_it.address == ADDR_STROBE) begin
                        if (r_strobe_nz && w_it.data == 8'd0) begin
                            n_toggle = ~r_toggle;
                        end
                        n_strobe_nz = |w_it.data;
                    end else begin
                        case (w_it.address & WR_MASK)
                            WR_BANK_LO: begin
                                n_split = w_it.data[7];
                                if (!w_it.data[7] && w_it.scanline < LINE_UPPER) begin
                                    n_pattern = PAT_FULL;
                                end
                                n_bank_reg = {r_bank_reg[7:4], w_it.data[3:0]};
                                n_mapped   = limit_bank(n_bank_reg, r_limit_val);
                            end
                            WR_BANK_HI: begin
                                n_bank_reg = {w_it.data[3:0], r_bank_reg[3:0]};
                                n_mapped   = limit_bank(n_bank_reg, r_limit_val);
                            end
                            WR_SECURITY: begin
                                n_security = w_it.data;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                CMD_READ: begin
                    case (w_it.address & RD_MASK)
                        RD_ID_0, RD_ID_2, RD_ID_3, RD_ID_4, RD_ID_6, RD_ID_7: begin
                            n_rd_data = READ_ID;
                        end
                        RD_SECURITY: begin
                            n_rd_data = r_security;
                        end
                        RD_TOGGLED: begin
                            n_rd_data = r_toggle ? r_security : 8'd0;
                        end
                        default: begin
                            n_rd_data = w_it.open_bus;
                        end
                    endcase
                end
                CMD_SCAN: begin
                    if (r_split && w_it.rendering_on && !w_it.in_vblank) begin
                        if (w_it.scanline == LINE_LOWER) begin
                            n_pattern = PAT_LOWER;
                        end else if (w_it.scanline == LINE_UPPER) begin
                            n_pattern = PAT_UPPER;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_val <= LIMIT_RESET;
            r_bank_reg  <= BANK_RESET;
            r_mapped    <= limit_bank(BANK_RESET, LIMIT_RESET);
            r_split     <= 1'b0;
            r_strobe_nz <= 1'b1;
            r_security  <= 8'd0;
            r_toggle    <= 1'b0;
            r_pattern   <= PAT_FULL;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit_val <= i_cfg_wdata;
            end
            r_bank_reg  <= n_bank_reg;
            r_mapped    <= n_mapped;
            r_split     <= n_split;
            r_strobe_nz <= n_strobe_nz;
            r_security  <= n_security;
            r_toggle    <= n_toggle;
            r_pattern   <= n_pattern;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rd_data <= n_rd_data;
        end
    end

    // bank and pattern mode are the state left by the item on display
    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_rd_data;
    assign o_out.prg_bank     = r_mapped;
    assign o_out.pattern_mode = r_pattern;

endmodule

### src/cartridge_bank_mapper_with_security.sv
// Cartridge bank controller with 32K program banking, a security latch and
// split pattern-table control. Each item is a CPU write, a CPU read or a
// scanline event; each gives one result with the read byte, the program bank
// mapped at 0x8000 and the pattern-table mode after that item. One item is
// accepted every cycle while results are taken; the input register takes the
// item at acceptance and the single decode and state-update stage loads the
// result register when it is empty or being read. A stalled result holds the
// input side once the input register is also full. The user writes the bank
// limit register via i_cfg_we/i_cfg_wdata while no item is in flight (not
// enforced by the block); it takes effect at the next bank register write.
module cartridge_bank_mapper_with_security (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    cbm_in_if.sink     i_in,
    cbm_out_if.source  o_out
);
    import cbm_pkg::*;

    t_stage w_stage;
    logic   w_take;

    cbm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (w_take),
        .o_stage (w_stage)
    );

    cbm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (w_stage),
        .o_take      (w_take),
        .o_out       (o_out)
    );

endmodule

### src/cbm_checker.sv
`include "cartridge_bank_mapper_with_security_defines.svh"

module cbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic [7:0] i_prg_bank,
    input logic [1:0] i_pattern_mode
);
    import cbm_pkg::*;

    // a stalled result keeps its payload
    `CBM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_read_data) && $stable(i_prg_bank) && $stable(i_pattern_mode), "stalled result changed")

    // bank and pattern mode move only together with a new result
    `CBM_ASSERT_IMP(a_state_with_item, i_clk, i_rst_n, !$stable(i_prg_bank) || !$stable(i_pattern_mode), i_out_valid, "mapping changed without a result")

    // an empty result register never blocks the input side
    `CBM_ASSERT_IMP(a_accept_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")

    // reset drops the output and restores the reset mapping
    `CBM_ASSERT_RST(a_reset_state, i_clk, i_rst_n, !i_out_valid && i_pattern_mode == PAT_FULL && i_prg_bank == BANK_RESET, "bad state after reset")

endmodule

bind cartridge_bank_mapper_with_security cbm_checker u_cbm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_read_data    (o_out.read_data),
    .i_prg_bank     (o_out.prg_bank),
    .i_pattern_mode (o_out.pattern_mode)
);

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cbm_pkg::*;

    // no command is assigned to the last code; the block must pass open bus
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] prg_bank;
        logic [1:0] pattern_mode;
    } t_mapper_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    cbm_in_if  in_if();
    cbm_out_if out_if();

    cartridge_bank_mapper_with_security dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // mirror of the mapper registers
    logic [7:0] bank_limit;
    logic [7:0] bank_reg;
    logic [7:0] mapped_bank;
    logic       split_on;
    logic [7:0] last_strobe;
    logic [7:0] security;
    logic       toggle_bit;
    logic [1:0] pattern_sel;

    t_mapper_result responses_due[$];

    int  fail_count;
    int  results_checked;
    int  items_sent;
    int  limit_writes;
    int  cmd_seen[4];
    int  idle_cycles;
    int  hold_len;
    bit  idle_on;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] masked_bank(input logic [7:0] bank);
        return (bank > bank_limit) ? (bank & bank_limit) : bank;
    endfunction

    function automatic t_mapper_result mapper_response(input t_item it);
        t_mapper_result r;
        r.read_data = it.open_bus;
        case (it.cmd)
            CMD_WRITE: begin
                if (it.address == ADDR_FORCE && it.data == DATA_FORCE) begin
                    // forced bank skips the limit and leaves the register alone
                    mapped_bank = FORCE_BANK;
                end else if (it.address == ADDR_STROBE) begin
                    if (last_strobe != 8'h00 && it.data == 8'h00) toggle_bit = ~toggle_bit;
                    last_strobe = it.data;
                end else begin
                    case (it.address & WR_MASK)
                        WR_BANK_LO: begin
                            split_on = it.data[7];
                            if (!split_on && it.scanline < LINE_UPPER) pattern_sel = PAT_FULL;
                            bank_reg[3:0] = it.data[3:0];
                            mapped_bank = masked_bank(bank_reg);
                        end
                        WR_BANK_HI: begin
                            bank_reg[7:4] = it.data[3:0];
                            mapped_bank = masked_bank(bank_reg);
                        end
                        WR_SECURITY: security = it.data;
                        default: ;
                    endcase
                end
            end
            CMD_READ: begin
                case (it.address & RD_MASK)
                    RD_ID_0, RD_ID_2, RD_ID_3, RD_ID_4, RD_ID_6, RD_ID_7: r.read_data = READ_ID;
                    RD_SECURITY: r.read_data = security;
                    RD_TOGGLED:  r.read_data = toggle_bit ? security : 8'h00;
                    default: ;
                endcase
            end
            CMD_SCAN: begin
                if (split_on && it.rendering_on && !it.in_vblank) begin
                    if (it.scanline == LINE_LOWER) pattern_sel = PAT_LOWER;
                    else if (it.scanline == LINE_UPPER) pattern_sel = PAT_UPPER;
                end
            end
            default: ;
        endcase
        r.prg_bank     = mapped_bank;
        r.pattern_mode = pattern_sel;
        return r;
    endfunction

    function automatic t_item make_item(input logic [1:0] cmd, input logic [15:0] address,
                                        input logic [7:0] data, input logic [7:0] open_bus,
                                        input logic [8:0] scanline, input logic rendering_on,
                                        input logic in_vblank);
        t_item it;
        it.cmd          = cmd;
        it.address      = address;
        it.data         = data;
        it.open_bus     = open_bus;
        it.scanline     = scanline;
        it.rendering_on = rendering_on;
        it.in_vblank    = in_vblank;
        return it;
    endfunction

    function automatic t_item random_access();
        t_item it;
        int    pick;
        it.data         = 8'($urandom);
        it.open_bus     = 8'($urandom);
        it.rendering_on = ($urandom_range(0, 3) != 0);
        it.in_vblank    = ($urandom_range(0, 3) == 0);
        it.address      = 16'($urandom);
        case ($urandom_range(0, 9))
            0: it.scanline = LINE_UPPER;
            1: it.scanline = LINE_LOWER;
            2: it.scanline = LINE_UPPER - 9'd1;
            default: it.scanline = 9'($urandom_range(0, 511));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.cmd = CMD_WRITE;
            // keep most writes on decoded registers, with alias bits set at random
            case ($urandom_range(0, 9))
                0, 1: begin
                    it.address = ADDR_FORCE;
                    if ($urandom_range(0, 1)) it.data = DATA_FORCE;
                end
                2, 3: begin
                    it.address = ADDR_STROBE;
                    if ($urandom_range(0, 1)) it.data = 8'h00;
                end
                4, 5: it.address = WR_BANK_LO | (16'($urandom) & ~WR_MASK);
                6: it.address = WR_BANK_HI | (16'($urandom) & ~WR_MASK);
                7: it.address = WR_SECURITY | (16'($urandom) & ~WR_MASK);
                8: it.address = ADDR_FORCE | (16'($urandom) & ~WR_MASK);
                default: ;
            endcase
        end else if (pick < 75) begin
            it.cmd = CMD_READ;
            if ($urandom_range(0, 4) != 0)
                it.address = RD_ID_0 | (16'($urandom_range(0, 7)) << 8)
                             | (16'($urandom) & ~RD_MASK);
        end else if (pick < 95) begin
            it.cmd = CMD_SCAN;
        end else begin
            it.cmd = CMD_NONE;
        end
        return it;
    endfunction

    // call at a falling edge; returns at a falling edge
    task automatic send_item(input t_item it);
        int gap;
        in_if.valid        <= 1'b1;
        in_if.cmd          <= it.cmd;
        in_if.address      <= it.address;
        in_if.data         <= it.data;
        in_if.open_bus     <= it.open_bus;
        in_if.scanline     <= it.scanline;
        in_if.rendering_on <= it.rendering_on;
        in_if.in_vblank    <= it.in_vblank;
        do @(posedge i_clk); while (!in_if.ready);
        responses_due.push_back(mapper_response(it));
        items_sent++;
        cmd_seen[it.cmd]++;
        @(negedge i_clk);
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (responses_due.size() != 0) @(negedge i_clk);
    endtask

    // only while nothing is in flight
    task automatic write_limit(input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        bank_limit = value;
        limit_writes++;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_item(make_item(CMD_READ, RD_ID_0, 8'h00, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, RD_SECURITY, 8'h00, 8'hFF, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, RD_TOGGLED, 8'h00, 8'h33, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, 16'hFFFF, 8'hFF, 8'hA5, 9'd511, 1'b1, 1'b1));
        send_item(make_item(CMD_READ, 16'h0000, 8'h00, 8'h5A, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, WR_SECURITY, 8'hFF, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, RD_SECURITY, 8'h00, 8'h00, 9'd0, 1'b0, 1'b0));
        // strobe falls from nonzero to zero: trigger flips once, then holds
        send_item(make_item(CMD_WRITE, ADDR_STROBE, 8'h00, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, RD_TOGGLED, 8'h00, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_STROBE, 8'h00, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, RD_ID_7, 8'h00, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_FORCE, DATA_FORCE, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_FORCE, 8'h07, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, WR_BANK_LO, 8'h8A, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, WR_BANK_HI, 8'hFF, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_SCAN, 16'h0000, 8'h00, 8'h00, LINE_UPPER, 1'b1, 1'b0));
        send_item(make_item(CMD_SCAN, 16'h0000, 8'h00, 8'h00, LINE_LOWER, 1'b1, 1'b1));
        send_item(make_item(CMD_SCAN, 16'h0000, 8'h00, 8'h00, LINE_LOWER, 1'b0, 1'b0));
        send_item(make_item(CMD_SCAN, 16'h0000, 8'h00, 8'h00, LINE_LOWER, 1'b1, 1'b0));
        send_item(make_item(CMD_SCAN, 16'hFFFF, 8'hFF, 8'hFF, 9'd511, 1'b1, 1'b0));
        // split off at or after line 128 keeps the mode, before it clears the mode
        send_item(make_item(CMD_WRITE, WR_BANK_LO, 8'h01, 8'h00, LINE_UPPER, 1'b1, 1'b0));
        send_item(make_item(CMD_WRITE, WR_BANK_LO, 8'h02, 8'h00, 9'd127, 1'b1, 1'b0));
        send_item(make_item(CMD_NONE, 16'hFFFF, 8'hFF, 8'hFF, 9'd511, 1'b1, 1'b1));
        send_item(make_item(CMD_NONE, 16'h0000, 8'h00, 8'h00, 9'd0, 1'b0, 1'b0));
        drain_results();
    endtask

    task automatic test_bank_limit();
        write_limit(8'h00);
        send_item(make_item(CMD_WRITE, WR_BANK_LO, 8'h05, 8'h00, 9'd200, 1'b0, 1'b0));
        drain_results();
        // new limit waits for the next bank register write
        write_limit(8'h07);
        send_item(make_item(CMD_READ, RD_ID_0, 8'h00, 8'h11, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, WR_BANK_HI, 8'h00, 8'h00, 9'd0, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, WR_BANK_LO, 8'h0C, 8'h00, 9'd200, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_FORCE, DATA_FORCE, 8'h00, 9'd0, 1'b0, 1'b0));
        drain_results();
        write_limit(LIMIT_RESET);
        send_item(make_item(CMD_WRITE, WR_BANK_HI, 8'hFF, 8'h00, 9'd0, 1'b0, 1'b0));
        drain_results();
    endtask

    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_len = 300;
        repeat (40) send_item(random_access());
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        repeat (150) send_item(random_access());
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        logic [7:0] limits[5];
        limits = '{8'h00, LIMIT_RESET, 8'($urandom_range(1, 254)), 8'h07, 8'h3C};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            repeat (260) send_item(random_access());
            drain_results();
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int rx_wait;
        rx_wait      = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                out_if.ready <= 1'b0;
                hold_len--;
            end else if (rx_wait > 0) begin
                out_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                out_if.ready <= 1'b1;
                if (idle_on) rx_wait = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_mapper_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_checked++;
            if (responses_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: read_data %h prg_bank %h pattern_mode %0d",
                             out_if.read_data, out_if.prg_bank, out_if.pattern_mode);
            end else begin
                want = responses_due.pop_front();
                if (out_if.read_data !== want.read_data || out_if.prg_bank !== want.prg_bank
                    || out_if.pattern_mode !== want.pattern_mode) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: read_data %h/%h prg_bank %h/%h ",
                                  "pattern_mode %0d/%0d (expected/actual)"},
                                 want.read_data, out_if.read_data, want.prg_bank,
                                 out_if.prg_bank, want.pattern_mode, out_if.pattern_mode);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d results still due", responses_due.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = 8'h00;
        in_if.valid        = 1'b0;
        in_if.cmd          = CMD_WRITE;
        in_if.address      = 16'h0000;
        in_if.data         = 8'h00;
        in_if.open_bus     = 8'h00;
        in_if.scanline     = 9'd0;
        in_if.rendering_on = 1'b0;
        in_if.in_vblank    = 1'b0;
        fail_count         = 0;
        results_checked    = 0;
        items_sent         = 0;
        limit_writes       = 0;
        idle_cycles        = 0;
        hold_len           = 0;
        idle_on            = 1'b1;
        foreach (cmd_seen[c]) cmd_seen[c] = 0;
        bank_limit         = LIMIT_RESET;
        bank_reg           = BANK_RESET;
        mapped_bank        = BANK_RESET;
        split_on           = 1'b0;
        last_strobe        = 8'h01;
        security           = 8'h00;
        toggle_bit         = 1'b0;
        pattern_sel        = PAT_FULL;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_bank_limit();
        test_backpressure();
        test_streaming();
        test_random();

        repeat (4) @(posedge i_clk);
        if (responses_due.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", responses_due.size());
        end
        $display("covered %0d items: %0d writes, %0d reads, %0d scanline events, %0d unused",
                 items_sent, cmd_seen[CMD_WRITE], cmd_seen[CMD_READ], cmd_seen[CMD_SCAN],
                 cmd_seen[CMD_NONE]);
        $display("checked %0d results across %0d bank limit settings, %0d failures",
                 results_checked, limit_writes, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/cbm_pkg.sv
src/cbm_if.sv
src/cbm_in_stage.sv
src/cbm_core.sv
src/cartridge_bank_mapper_with_security.sv
src/cbm_checker.sv
verif/testbench.sv
